>>> hw/rtl/gut_pkg.sv
// shared types, byte codes and the letter table of the transliterator
package gut_pkg;

  localparam logic [7:0] LEAD_BYTE = 8'hE1;
  localparam logic [7:0] MID_BYTE  = 8'h83;
  localparam logic [7:0] TAIL_LOW  = 8'h90;
  localparam logic [7:0] TAIL_HIGH = 8'hBF;

  // one run of output bytes caused by a single input beat, first byte in slot 0
  typedef struct packed {
    logic [0:3][7:0] bytes;
    logic [2:0]      len;
    logic            text_end;
  } run_t;

  // request from the front part into the run queue
  typedef struct packed {
    logic valid;
    run_t run;
  } q_push_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // latin replacement of one letter
  typedef struct packed {
    logic [2:0]       len;
    logic [0:3][7:0]  bytes;
  } latin_t;

  // indexed by code point minus U+10D0; zero length means unmapped
  function automatic latin_t latin_lookup(input logic [5:0] idx);
    latin_t m;
    case (idx)
      6'd0:    m = '{3'd1, 32'h6100_0000};
      6'd1:    m = '{3'd1, 32'h6200_0000};
      6'd2:    m = '{3'd1, 32'h6700_0000};
      6'd3:    m = '{3'd1, 32'h6400_0000};
      6'd4:    m = '{3'd1, 32'h6500_0000};
      6'd5:    m = '{3'd1, 32'h7600_0000};
      6'd6:    m = '{3'd1, 32'h7A00_0000};
      6'd7:    m = '{3'd2, 32'h7468_0000};
      6'd8:    m = '{3'd1, 32'h6900_0000};
      6'd9:    m = '{3'd1, 32'h6B00_0000};
      6'd10:   m = '{3'd1, 32'h6C00_0000};
      6'd11:   m = '{3'd1, 32'h6D00_0000};
      6'd12:   m = '{3'd1, 32'h6E00_0000};
      6'd13:   m = '{3'd1, 32'h6F00_0000};
      6'd14:   m = '{3'd1, 32'h7000_0000};
      6'd15:   m = '{3'd2, 32'hC5BE_0000};
      6'd16:   m = '{3'd1, 32'h7200_0000};
      6'd17:   m = '{3'd1, 32'h7300_0000};
      6'd18:   m = '{3'd1, 32'h7400_0000};
      6'd19:   m = '{3'd1, 32'h7500_0000};
      6'd20:   m = '{3'd2, 32'h7068_0000};
      6'd21:   m = '{3'd2, 32'h6B68_0000};
      6'd22:   m = '{3'd3, 32'hE1B8_A100};
      6'd23:   m = '{3'd1, 32'h7100_0000};
      6'd24:   m = '{3'd2, 32'hC5A1_0000};
      6'd25:   m = '{3'd4, 32'hC48D_C48D};
      6'd26:   m = '{3'd2, 32'h6363_0000};
      6'd27:   m = '{3'd2, 32'h647A_0000};
      6'd28:   m = '{3'd1, 32'h6300_0000};
      6'd29:   m = '{3'd2, 32'hC48D_0000};
      6'd30:   m = '{3'd1, 32'h7800_0000};
      6'd31:   m = '{3'd1, 32'h6A00_0000};
      6'd32:   m = '{3'd1, 32'h6800_0000};
      6'd33:   m = '{3'd2, 32'h6579_0000};
      6'd34:   m = '{3'd2, 32'h7965_0000};
      6'd35:   m = '{3'd1, 32'h7700_0000};
      6'd36:   m = '{3'd2, 32'h7168_0000};
      6'd37:   m = '{3'd2, 32'hC58D_0000};
      6'd39:   m = '{3'd2, 32'hC3AB_0000};
      6'd40:   m = '{3'd1, 32'h2700_0000};
      default: m = '{3'd0, 32'h0000_0000};
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/gut_front.sv
// front part: prefix tracking and classification of each input beat into a run
module gut_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_text_last,
  input  gut_pkg::q_stat_t  q_stat,
  output gut_pkg::q_push_t  push
);
  import gut_pkg::*;

  typedef enum logic [2:0] {
    STG_IDLE = 3'b001,
    STG_LEAD = 3'b010,
    STG_MID  = 3'b100
  } stage_t;

  stage_t     stage_r, stage_nxt;
  run_t       run;
  latin_t     lat;
  logic [5:0] tail_off;
  logic       in_tail;
  logic       accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign tail_off = 6'(in_byte - TAIL_LOW);
  assign in_tail  = (in_byte >= TAIL_LOW) && (in_byte <= TAIL_HIGH);
  assign lat      = latin_lookup(tail_off);

  // classify the beat against the pending prefix
  always_comb begin
    stage_nxt    = STG_IDLE;
    run.bytes    = '0;
    run.len      = 3'd0;
    run.text_end = in_text_last;
    unique case (stage_r)
      STG_LEAD: begin
        if (in_byte == MID_BYTE) begin
          if (in_text_last) begin
            run.bytes = {LEAD_BYTE, MID_BYTE, 16'h0000};
            run.len   = 3'd2;
          end else begin
            stage_nxt = STG_MID;
          end
        end else if (in_byte == LEAD_BYTE) begin
          if (in_text_last) begin
            run.bytes = {LEAD_BYTE, LEAD_BYTE, 16'h0000};
            run.len   = 3'd2;
          end else begin
            run.bytes = {LEAD_BYTE, 24'h000000};
            run.len   = 3'd1;
            stage_nxt = STG_LEAD;
          end
        end else begin
          run.bytes = {LEAD_BYTE, in_byte, 16'h0000};
          run.len   = 3'd2;
        end
      end
      STG_MID: begin
        if (in_tail) begin
          if (lat.len != 3'd0) begin
            run.bytes = lat.bytes;
            run.len   = lat.len;
          end else begin
            // unmapped letter goes out as its own three bytes
            run.bytes = {LEAD_BYTE, MID_BYTE, in_byte, 8'h00};
            run.len   = 3'd3;
          end
        end else if (in_byte == LEAD_BYTE) begin
          if (in_text_last) begin
            run.bytes = {LEAD_BYTE, MID_BYTE, LEAD_BYTE, 8'h00};
            run.len   = 3'd3;
          end else begin
            run.bytes = {LEAD_BYTE, MID_BYTE, 16'h0000};
            run.len   = 3'd2;
            stage_nxt = STG_LEAD;
          end
        end else begin
          run.bytes = {LEAD_BYTE, MID_BYTE, in_byte, 8'h00};
          run.len   = 3'd3;
        end
      end
      default: begin
        if (in_byte == LEAD_BYTE) begin
          if (in_text_last) begin
            run.bytes = {LEAD_BYTE, 24'h000000};
            run.len   = 3'd1;
          end else begin
            stage_nxt = STG_LEAD;
          end
        end else begin
          run.bytes = {in_byte, 24'h000000};
          run.len   = 3'd1;
        end
      end
    endcase
  end

  // only beats that produce bytes enter the queue
  assign push.valid = accept && (run.len != 3'd0);
  assign push.run   = run;

  // prefix state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= STG_IDLE;
    end else if (accept) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

>>> hw/rtl/gut_queue.sv
// two-entry run queue between the front and back parts
module gut_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  gut_pkg::q_push_t  push,
  input  logic              pop,
  output gut_pkg::run_t     head,
  output gut_pkg::q_stat_t  q_stat
);
  import gut_pkg::*;

  run_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = push.valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // run storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.run;
    end
  end

endmodule

>>> hw/rtl/gut_back.sv
// back part: sends the bytes of the head run one beat at a time
module gut_back (
  input  logic              clk,
  input  logic              rst_n,
  input  gut_pkg::run_t     head,
  input  gut_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_text_end
);
  import gut_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       at_last;
  logic       beat;

  assign out_valid    = !q_stat.empty;
  assign out_byte     = head.bytes[idx_r];
  assign at_last      = ({1'b0, idx_r} + 3'd1) == head.len;
  assign out_run_last = at_last;
  assign out_text_end = at_last && head.text_end;
  assign beat         = out_valid && out_ready;
  assign pop          = beat && at_last;

  // byte index within the head run
  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (beat) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> hw/rtl/georgian_utf8_transliterator_unit.sv
// top level of the georgian to latin utf-8 transliterator
//
// Input channel (in_valid/in_ready): one text byte per beat with in_text_last
// on the final byte of the text. Output channel (out_valid/out_ready): one
// result byte per beat; out_run_last marks the last byte caused by one input
// beat, out_text_end the final byte of the whole text.
// The bytes E1 and E1 83 are held back until the letter completes or breaks;
// mapped letters are replaced by 1 to 4 latin bytes, everything else is copied.
// Each run is registered in the queue before its first byte appears on out_byte.
// Throughput: one input beat per cycle while runs are one byte long and out_ready
// stays high; a longer run holds the output until all its bytes have gone out on the single output byte lane.
// The run queue stores up to two runs between the parts, so input is taken while a
// result waits; in_ready drops only when both queue entries are full.
// Reset clears the prefix state, the queue and the byte index.
// A stalled receiver keeps out_byte steady and fills the queue, then stalls
// the sender; no byte is dropped or repeated.
module georgian_utf8_transliterator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);
  import gut_pkg::*;

  q_push_t push;
  q_stat_t q_stat;
  run_t    head;
  logic    pop;

  // classification of input beats
  gut_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .q_stat       (q_stat),
    .push         (push)
  );

  // run queue
  gut_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // byte sequencer
  gut_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  // a run at the queue head always holds one to four bytes
  a_head_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.len != 3'd0) && (head.len <= 3'd4))
    else $error("queue head run has an illegal length");

  // the final text byte always produces a run
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_text_last) |-> push.valid)
    else $error("end of text produced no output run");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_stat.full)
    else $error("run pushed into a full queue");

  // a pop with no push never leaves the queue full
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.valid && q_stat.empty == 1'b0 && $past(q_stat.empty))
      |=> (q_stat.empty || !q_stat.full))
    else $error("queue count went wrong after a pop");

endmodule
